FILE: rtl/cisr_pkg.sv
// Shared types and constants of the CAN ISO-TP response reassembler.
// Used by every module under rtl/ except cisr_ram; depends on nothing else.
package cisr_pkg;

  localparam int DefaultMessageBytes = 64;
  localparam int DefaultChannels     = 2;
  localparam int RespChannels        = 2;   // engine and transmission reply channels
  localparam int MaxResults          = 64;  // cap on emitted message bytes
  localparam int IdxMaxW             = 8;   // store index width at the largest store size
  localparam int CfgIdxW             = 3;
  localparam int IdW                 = 11;

  localparam logic [7:0] SvcMode01Pos = 8'h41;
  localparam logic [7:0] SvcRdbiPos   = 8'h62;
  localparam logic [3:0] PciSingle    = 4'h0;
  localparam logic [3:0] PciFirst     = 4'h1;
  localparam logic [3:0] PciConsec    = 4'h2;
  localparam logic [2:0] SfMaxLen     = 3'd7;
  localparam logic [2:0] FfBytes      = 3'd6;
  localparam logic [2:0] CfBytes      = 3'd7;
  localparam logic [6:0] MinMsgLen    = 7'd3;

  localparam logic [IdW-1:0] RstRespOffset = 11'd8;
  localparam logic [IdW-1:0] RstFuelId     = 11'd1544;
  localparam logic [IdW-1:0] RstGearId     = 11'd536;
  localparam logic [IdW-1:0] RstEngineId   = 11'd2024;
  localparam logic [IdW-1:0] RstGearboxId  = 11'd2025;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RESP_OFFSET = 3'd0,
    REG_FUEL_ID     = 3'd1,
    REG_GEAR_ID     = 3'd2,
    REG_ENGINE_ID   = 3'd3,
    REG_GEARBOX_ID  = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    KIND_FUEL      = 3'd0,
    KIND_GEAR      = 3'd1,
    KIND_MODE01    = 3'd2,
    KIND_FLOW_CTRL = 3'd3,
    KIND_MSG_BYTE  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    OP_RESULT = 2'd0,  // one ready-made result
    OP_SF_MSG = 2'd1,  // message bytes carried in the request itself
    OP_FIRST  = 2'd2,  // store bytes, then flow-control result
    OP_CONSEC = 2'd3   // store bytes, then maybe replay the message from the store
  } op_e;

  typedef struct packed {
    logic [IdW-1:0] response_offset;
    logic [IdW-1:0] fuel_broadcast_id;
    logic [IdW-1:0] gear_broadcast_id;
    logic [IdW-1:0] engine_response_id;
    logic [IdW-1:0] gearbox_response_id;
  } cfg_t;

  typedef struct packed {
    logic [10:0] can_id;
    logic [3:0]  length_code;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [7:0]  byte6;
    logic [7:0]  byte7;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic        ecu;
    logic [7:0]  tag;
    logic [31:0] value;
    logic        last;
  } out_t;

  typedef struct packed {
    op_e                op;
    logic               ch;
    kind_e              kind;
    logic [7:0]         tag;
    logic [31:0]        value;
    logic [55:0]        data;    // payload bytes, first byte in the low bits
    logic [IdxMaxW-1:0] wr_idx;
    logic [2:0]         wr_cnt;
    logic [6:0]         rd_len;
  } cmd_t;

endpackage

FILE: rtl/cisr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cisr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/cisr_cmd_fifo.sv
// Two-entry request queue between the frame classifier and the executor.
// Depends on cisr_pkg.
module cisr_cmd_fifo import cisr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/cisr_front.sv
// Frame classifier: matches ids, tracks per-channel ISO-TP reassembly state
// and turns each frame into at most one request. Depends on cisr_pkg.
module cisr_front import cisr_pkg::*; #(
  parameter int MESSAGE_BYTES = DefaultMessageBytes,
  parameter int CHANNELS      = DefaultChannels
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  in_t  frame_i,
  input  logic accept_i,
  output cmd_t cmd_o,
  output logic cmd_valid_o
);

  localparam int ColW = $clog2(MESSAGE_BYTES + 1);

  logic [RespChannels-1:0] act_q, act_d;
  logic [RespChannels-1:0] head_ok_q, head_ok_d;   // stored byte 0 is 0x62
  logic [11:0]             exp_q [RespChannels];
  logic [11:0]             exp_d [RespChannels];
  logic [ColW-1:0]         col_q [RespChannels];
  logic [ColW-1:0]         col_d [RespChannels];

  logic        fuel_hit, gear_hit, resp_hit, ch, ch_en, has_cmd;
  logic [3:0]  pci, sf_nib;
  logic [2:0]  sf_len, ff_cnt, cf_cnt;
  logic [11:0] ff_exp;
  logic [12:0] exp_w, col_w, rem_exp, rem_mb, room, newcol;
  logic        cf_done, cf_emit;
  logic [6:0]  msg_len;
  logic [55:0] tail7;

  assign fuel_hit = (frame_i.can_id == cfg_i.fuel_broadcast_id) && (frame_i.length_code >= 4'd7);
  assign gear_hit = (frame_i.can_id == cfg_i.gear_broadcast_id) && (frame_i.length_code >= 4'd3);
  assign resp_hit = (frame_i.can_id == cfg_i.engine_response_id) ||
                    (frame_i.can_id == cfg_i.gearbox_response_id);
  assign ch       = (frame_i.can_id != cfg_i.engine_response_id);
  assign ch_en    = !ch || (CHANNELS > 1);
  assign pci      = frame_i.byte0[7:4];
  assign sf_nib   = frame_i.byte0[3:0];
  assign sf_len   = (sf_nib > 4'(SfMaxLen)) ? SfMaxLen : sf_nib[2:0];

  assign tail7 = {frame_i.byte7, frame_i.byte6, frame_i.byte5, frame_i.byte4,
                  frame_i.byte3, frame_i.byte2, frame_i.byte1};

  // First frame always starts from an empty buffer; the store holds at least 8 bytes.
  assign ff_exp = {frame_i.byte0[3:0], frame_i.byte1};
  assign ff_cnt = (ff_exp > 12'(FfBytes)) ? FfBytes : ff_exp[2:0];

  // Consecutive frame: bytes still fit below both the announced length and the store.
  assign exp_w   = {1'b0, exp_q[ch]};
  assign col_w   = 13'(col_q[ch]);
  assign rem_exp = exp_w - col_w;
  assign rem_mb  = 13'(MESSAGE_BYTES) - col_w;
  assign room    = (rem_exp < rem_mb) ? rem_exp : rem_mb;
  assign cf_cnt  = (room > 13'(CfBytes)) ? CfBytes : room[2:0];
  assign newcol  = col_w + 13'(cf_cnt);
  assign cf_done = (newcol >= exp_w);
  assign msg_len = (exp_w > 13'(MaxResults)) ? 7'(MaxResults) : exp_w[6:0];
  assign cf_emit = cf_done && (exp_w >= 13'(MinMsgLen)) && head_ok_q[ch];

  always_comb begin
    cmd_o     = '0;
    has_cmd   = 1'b0;
    act_d     = act_q;
    head_ok_d = head_ok_q;
    exp_d     = exp_q;
    col_d     = col_q;
    cmd_o.ch  = ch;
    if (fuel_hit) begin
      has_cmd     = 1'b1;
      cmd_o.op    = OP_RESULT;
      cmd_o.ch    = 1'b0;
      cmd_o.kind  = KIND_FUEL;
      cmd_o.value = {16'd0, frame_i.byte5, frame_i.byte6};
    end else if (gear_hit) begin
      has_cmd     = 1'b1;
      cmd_o.op    = OP_RESULT;
      cmd_o.ch    = 1'b0;
      cmd_o.kind  = KIND_GEAR;
      cmd_o.tag   = {4'd0, frame_i.byte2[7:4]};
      cmd_o.value = {28'd0, frame_i.byte2[3:0]};
    end else if (resp_hit) begin
      if (pci == PciSingle) begin
        if (frame_i.byte1 == SvcMode01Pos && !ch) begin
          has_cmd     = 1'b1;
          cmd_o.op    = OP_RESULT;
          cmd_o.kind  = KIND_MODE01;
          cmd_o.tag   = frame_i.byte2;
          cmd_o.value = {frame_i.byte3, frame_i.byte4, frame_i.byte5, frame_i.byte6};
        end else if (frame_i.byte1 == SvcRdbiPos && 7'(sf_len) >= MinMsgLen) begin
          has_cmd      = 1'b1;
          cmd_o.op     = OP_SF_MSG;
          cmd_o.data   = tail7;
          cmd_o.rd_len = 7'(sf_len);
        end
      end else if (ch_en && pci == PciFirst) begin
        has_cmd        = 1'b1;
        cmd_o.op       = OP_FIRST;
        cmd_o.kind     = KIND_FLOW_CTRL;
        cmd_o.value    = 32'(IdW'(frame_i.can_id - cfg_i.response_offset));
        cmd_o.data     = {8'd0, tail7[55:8]};
        cmd_o.wr_cnt   = ff_cnt;
        act_d[ch]      = 1'b1;
        head_ok_d[ch]  = (frame_i.byte2 == SvcRdbiPos);
        exp_d[ch]      = ff_exp;
        col_d[ch]      = ColW'(ff_cnt);
      end else if (ch_en && pci == PciConsec && act_q[ch]) begin
        has_cmd      = 1'b1;
        cmd_o.op     = OP_CONSEC;
        cmd_o.kind   = KIND_MSG_BYTE;
        cmd_o.data   = tail7;
        cmd_o.wr_idx = IdxMaxW'(col_q[ch]);
        cmd_o.wr_cnt = cf_cnt;
        cmd_o.rd_len = cf_emit ? msg_len : 7'd0;
        col_d[ch]    = ColW'(newcol);
        if (cf_done) begin
          act_d[ch] = 1'b0;
        end
      end
    end
  end

  assign cmd_valid_o = accept_i && has_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= '0;
      head_ok_q <= '0;
      for (int i = 0; i < RespChannels; i++) begin
        exp_q[i] <= '0;
        col_q[i] <= '0;
      end
    end else if (accept_i) begin
      act_q     <= act_d;
      head_ok_q <= head_ok_d;
      exp_q     <= exp_d;
      col_q     <= col_d;
    end
  end

endmodule

FILE: rtl/cisr_back.sv
// Request executor: writes frame bytes into the message store and produces
// result items into the output register. Depends on cisr_pkg and cisr_ram.
module cisr_back import cisr_pkg::*; #(
  parameter int MESSAGE_BYTES = DefaultMessageBytes,
  parameter int CHANNELS      = DefaultChannels
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic cmd_valid_i,
  output logic cmd_pop_o,
  output out_t out_item_o,
  output logic out_valid_o,
  input  logic out_pop_i
);

  localparam int NumCh    = (CHANNELS < 2) ? 1 : 2;
  localparam int MemDepth = NumCh * MESSAGE_BYTES;
  localparam int AW       = $clog2(MemDepth);
  localparam int IdxW     = $clog2(MESSAGE_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_ONE,
    ST_SF,
    ST_MEM
  } state_e;

  state_e          st_q;
  cmd_t            cmd_q;
  logic [55:0]     data_q;
  logic [IdxW-1:0] wr_pos_q;
  logic [2:0]      wr_left_q;
  logic [5:0]      em_q;
  logic            rd_ok_q;
  out_t            out_q;
  logic            out_valid_q;

  logic          can_load, out_load, em_last, ram_we;
  logic [AW-1:0] base, waddr, raddr;
  logic [7:0]    ram_rdata;

  assign can_load  = !out_valid_q || out_pop_i;
  // a result goes into the output register this cycle
  assign out_load  = can_load && ((st_q == ST_ONE) || (st_q == ST_SF) ||
                                  ((st_q == ST_MEM) && rd_ok_q));
  assign em_last   = ({1'b0, em_q} == (cmd_q.rd_len - 7'd1));
  assign base      = cmd_q.ch ? AW'(MESSAGE_BYTES) : '0;
  assign waddr     = base + AW'(wr_pos_q);
  assign raddr     = base + AW'(em_q);
  assign ram_we    = (st_q == ST_WRITE);
  assign cmd_pop_o = (st_q == ST_IDLE) && cmd_valid_i;

  assign out_item_o  = out_q;
  assign out_valid_o = out_valid_q;

  cisr_ram #(
    .WIDTH (8),
    .DEPTH (MemDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (data_q[7:0]),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      cmd_q       <= '0;
      data_q      <= '0;
      wr_pos_q    <= '0;
      wr_left_q   <= '0;
      em_q        <= '0;
      rd_ok_q     <= 1'b0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q     <= cmd_i;
            data_q    <= cmd_i.data;
            wr_pos_q  <= IdxW'(cmd_i.wr_idx);
            wr_left_q <= cmd_i.wr_cnt;
            em_q      <= '0;
            rd_ok_q   <= 1'b0;
            case (cmd_i.op)
              OP_RESULT: st_q <= ST_ONE;
              OP_SF_MSG: st_q <= ST_SF;
              default: begin
                if (cmd_i.wr_cnt != 3'd0) begin
                  st_q <= ST_WRITE;
                end else if (cmd_i.op == OP_FIRST) begin
                  st_q <= ST_ONE;
                end else if (cmd_i.rd_len != 7'd0) begin
                  st_q <= ST_MEM;
                end else begin
                  st_q <= ST_IDLE;
                end
              end
            endcase
          end
        end
        ST_WRITE: begin
          data_q    <= data_q >> 8;
          wr_pos_q  <= wr_pos_q + IdxW'(1);
          wr_left_q <= wr_left_q - 3'd1;
          if (wr_left_q == 3'd1) begin
            if (cmd_q.op == OP_FIRST) begin
              st_q <= ST_ONE;
            end else if (cmd_q.rd_len != 7'd0) begin
              st_q <= ST_MEM;
            end else begin
              st_q <= ST_IDLE;
            end
          end
        end
        ST_ONE: begin
          if (can_load) begin
            out_q <= '{kind: cmd_q.kind, ecu: cmd_q.ch, tag: cmd_q.tag,
                       value: cmd_q.value, last: 1'b1};
            st_q  <= ST_IDLE;
          end
        end
        ST_SF: begin
          if (can_load) begin
            out_q  <= '{kind: KIND_MSG_BYTE, ecu: cmd_q.ch, tag: 8'(em_q),
                        value: 32'(data_q[7:0]), last: em_last};
            data_q <= data_q >> 8;
            em_q   <= em_q + 6'd1;
            if (em_last) begin
              st_q <= ST_IDLE;
            end
          end
        end
        ST_MEM: begin
          // read data is good in the cycle after the address settles
          if (rd_ok_q && can_load) begin
            out_q   <= '{kind: KIND_MSG_BYTE, ecu: cmd_q.ch, tag: 8'(em_q),
                         value: 32'(ram_rdata), last: em_last};
            em_q    <= em_q + 6'd1;
            rd_ok_q <= 1'b0;
            if (em_last) begin
              st_q <= ST_IDLE;
            end
          end else begin
            rd_ok_q <= 1'b1;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/can_isotp_response_reassembler_unit.sv
// Top level of the CAN ISO-TP response reassembler: configuration registers,
// classifier, request queue and executor. Depends on cisr_pkg and all rtl modules.
//
// Usage:
//   Input side is a queue write port: present a received frame on in_item_i
//   and raise push; it is taken at a clock edge with push high and full low.
//   Results are read like a queue: while empty is low the oldest result sits
//   on out_item_o, and pop takes it. The last result of a frame has last set.
//   Configuration: cfg_index_i selects response offset, fuel id, gear id,
//   engine id or gearbox id (0..4); the write happens on cfg_valid_i with
//   cfg_ready_o, which is always high. Write only while the block is idle.
// Timing:
//   A frame is classified in the cycle it is taken and parked in a two-entry
//   request queue. The executor fetches a request, writes its stored bytes
//   (up to 7) one by one into the message store, then emits its results.
//   Bytes replayed from the message store go through a registered RAM read.
//   When the receiver stops popping, the executor holds and the queue fills,
//   then full rises.
// Reset clears channel state and loads the default ids; the message store is
// not cleared and needs no clearing pass.
module can_isotp_response_reassembler_unit import cisr_pkg::*; #(
  parameter int MESSAGE_BYTES = DefaultMessageBytes,
  parameter int CHANNELS      = DefaultChannels
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [IdW-1:0]     cfg_data_i,
  input  logic               push,
  output logic               full,
  input  in_t                in_item_i,
  output logic               empty,
  input  logic               pop,
  output out_t               out_item_o
);

  cfg_t cfg_q;
  logic accept, cmd_push, cmd_full, cmd_valid, cmd_pop, out_valid;
  cmd_t cmd_in, cmd_out;

  assign cfg_ready_o = 1'b1;
  assign full        = cmd_full;
  assign accept      = push && !cmd_full;
  assign empty       = !out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{response_offset:     RstRespOffset,
                 fuel_broadcast_id:   RstFuelId,
                 gear_broadcast_id:   RstGearId,
                 engine_response_id:  RstEngineId,
                 gearbox_response_id: RstGearboxId};
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_RESP_OFFSET: cfg_q.response_offset     <= cfg_data_i;
        REG_FUEL_ID:     cfg_q.fuel_broadcast_id   <= cfg_data_i;
        REG_GEAR_ID:     cfg_q.gear_broadcast_id   <= cfg_data_i;
        REG_ENGINE_ID:   cfg_q.engine_response_id  <= cfg_data_i;
        REG_GEARBOX_ID:  cfg_q.gearbox_response_id <= cfg_data_i;
        default:         cfg_q <= cfg_q;
      endcase
    end
  end

  cisr_front #(
    .MESSAGE_BYTES (MESSAGE_BYTES),
    .CHANNELS      (CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .frame_i     (in_item_i),
    .accept_i    (accept),
    .cmd_o       (cmd_in),
    .cmd_valid_o (cmd_push)
  );

  cisr_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_out)
  );

  cisr_back #(
    .MESSAGE_BYTES (MESSAGE_BYTES),
    .CHANNELS      (CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .out_item_o  (out_item_o),
    .out_valid_o (out_valid),
    .out_pop_i   (pop)
  );

`ifndef SYNTHESIS
  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !cmd_full)
    else $error("request queue written while full");

  a_single_result_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.kind != KIND_MSG_BYTE) |-> out_item_o.last)
    else $error("non-message result without last");

  a_msg_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.kind == KIND_MSG_BYTE && out_item_o.tag == 8'd0)
      |-> (out_item_o.value == 32'(SvcRdbiPos)))
    else $error("emitted message does not start with the positive reply code");
`endif

endmodule
